### design/obu_pkg.sv
// Shared types and constants for the order book level update block.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package obu_pkg;

  // Table geometry and field widths.
  localparam int LEVELS      = 16;
  localparam int PRICE_BITS  = 32;
  localparam int QTY_BITS    = 32;
  localparam int CNT_W       = $clog2(LEVELS + 1);
  localparam int FIELD_PRICE = 32;
  localparam int FIELD_QTY   = 32;
  localparam int FIELD_COUNT = 5;

  // Book sides.
  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_MISSED   = 3'd3,
    ST_EVICTED  = 3'd4,
    ST_DROPPED  = 3'd5
  } status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_APPLY
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Register the beat and the compare results.
    logic apply;    // Update the table and load the result register.
  } cmd_t;

endpackage
`default_nettype wire

### design/order_book_level_update.sv
// A taken input beat and its compare results are captured in the idle state;
// the apply state then writes back the shifted table and loads the result
// register. No new beat is taken until the apply is done. A result waiting
// at the output holds the next beat in the apply state.
// Reset clears both occupied counts; table entries stay undefined until
// written and need no clearing pass.
// Top level of the order book level update block.
// Depends on obu_pkg, obu_ctrl and obu_datapath.
`default_nettype none
module order_book_level_update
  import obu_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire                     side_i,
  input  wire  [FIELD_PRICE-1:0]  price_i,
  input  wire  [FIELD_QTY-1:0]    qty_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output logic [2:0]              status_o,
  output logic [FIELD_PRICE-1:0]  best_price_o,
  output logic [FIELD_QTY-1:0]    best_qty_o,
  output logic [FIELD_COUNT-1:0]  level_count_o
);

  cmd_t cmd;

  // Handshake and sequencing.
  obu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Tables, compare cells and result register.
  obu_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .side_i        (side_i),
    .price_i       (price_i),
    .qty_i         (qty_i),
    .status_o      (status_o),
    .best_price_o  (best_price_o),
    .best_qty_o    (best_qty_o),
    .level_count_o (level_count_o)
  );

endmodule
`default_nettype wire

### design/obu_ctrl.sv
// Controller state machine of the order book level update block.
// Depends on obu_pkg; drives the datapath through cmd_t.
`default_nettype none
module obu_ctrl
  import obu_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output cmd_t cmd_o
);

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // State and result valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.apply   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_APPLY;
        end
      end
      S_APPLY: begin
        // The result register must be free before it is overwritten.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.apply = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // A result beat stays valid until it is taken.
  always_comb begin
    if (cmd_o.apply) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // A pending result is never overwritten before it is taken.
  a_apply_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while pending");

  // A captured beat is applied from the next cycle on.
  a_capture_then_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == S_APPLY))
    else $error("captured beat not followed by apply state");

  // Every apply presents a result on the next cycle.
  a_apply_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |=> out_valid_q)
    else $error("apply did not raise result valid");

  // No new beat is taken while one is being applied.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && cmd_o.apply))
    else $error("input accepted during apply");

endmodule
`default_nettype wire

### design/obu_datapath.sv
// Datapath of the order book level update block: both sorted level tables,
// the per-level compare cells, the shift network and the result register.
// Depends on obu_pkg; controlled by obu_ctrl through cmd_t.
`default_nettype none
module obu_datapath
  import obu_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  cmd_t                    cmd_i,
  input  wire                     side_i,
  input  wire  [FIELD_PRICE-1:0]  price_i,
  input  wire  [FIELD_QTY-1:0]    qty_i,
  output logic [2:0]              status_o,
  output logic [FIELD_PRICE-1:0]  best_price_o,
  output logic [FIELD_QTY-1:0]    best_qty_o,
  output logic [FIELD_COUNT-1:0]  level_count_o
);

  // Level tables, one row per side, best level at index 0.
  logic [PRICE_BITS-1:0] pr_q [2][LEVELS];
  logic [QTY_BITS-1:0]   qt_q [2][LEVELS];
  logic [CNT_W-1:0]      cnt_q [2];

  // Captured beat and compare results.
  logic                  side_q;
  logic [PRICE_BITS-1:0] p_q;
  logic [QTY_BITS-1:0]   q_q;
  logic [CNT_W-1:0]      n_q;
  logic [LEVELS-1:0]     eq_q;
  logic [LEVELS-1:0]     ahead_q;

  // Result register.
  status_e               status_q;
  logic [FIELD_PRICE-1:0] best_price_q;
  logic [FIELD_QTY-1:0]  best_qty_q;
  logic [FIELD_COUNT-1:0] count_q;

  // Compare stage signals.
  logic [PRICE_BITS-1:0] p_in;
  logic [CNT_W-1:0]      n_in;
  logic [LEVELS-1:0]     eq_d;
  logic [LEVELS-1:0]     ahead_d;

  // Apply stage signals.
  logic                  hit;
  logic                  full;
  logic                  drop;
  logic [LEVELS-1:0]     vld;
  logic [LEVELS-1:0]     prev_ahead;
  logic [PRICE_BITS-1:0] cur_pr  [LEVELS];
  logic [QTY_BITS-1:0]   cur_qt  [LEVELS];
  logic [PRICE_BITS-1:0] nxt_pr  [LEVELS];
  logic [QTY_BITS-1:0]   nxt_qt  [LEVELS];
  logic [PRICE_BITS-1:0] up_pr   [LEVELS];
  logic [QTY_BITS-1:0]   up_qt   [LEVELS];
  logic [PRICE_BITS-1:0] dn_pr   [LEVELS];
  logic [QTY_BITS-1:0]   dn_qt   [LEVELS];
  logic [CNT_W-1:0]      n_next;
  status_e               status_d;

  // Compare cells: each occupied level against the incoming price.
  assign p_in = PRICE_BITS'(price_i);
  assign n_in = cnt_q[side_i];

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      logic occ;
      logic [PRICE_BITS-1:0] e;
      occ = (CNT_W'(i) < n_in);
      e   = pr_q[side_i][i];
      eq_d[i] = occ && (e == p_in);
      if (side_i == SIDE_ASK) begin
        ahead_d[i] = occ && (e < p_in);
      end else begin
        ahead_d[i] = occ && (e > p_in);
      end
    end
  end

  // Beat and compare registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      side_q  <= side_i;
      p_q     <= p_in;
      q_q     <= QTY_BITS'(qty_i);
      n_q     <= n_in;
      eq_q    <= eq_d;
      ahead_q <= ahead_d;
    end
  end

  // Neighbour views of the addressed row for the shift network.
  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      cur_pr[i] = pr_q[side_q][i];
      cur_qt[i] = qt_q[side_q][i];
      vld[i]    = (CNT_W'(i) < n_q);
    end
    for (int i = 0; i < LEVELS; i++) begin
      if (i < LEVELS - 1) begin
        up_pr[i] = cur_pr[i + 1];
        up_qt[i] = cur_qt[i + 1];
      end else begin
        up_pr[i] = cur_pr[i];
        up_qt[i] = cur_qt[i];
      end
      if (i > 0) begin
        dn_pr[i] = cur_pr[i - 1];
        dn_qt[i] = cur_qt[i - 1];
      end else begin
        dn_pr[i] = cur_pr[i];
        dn_qt[i] = cur_qt[i];
      end
    end
    prev_ahead = {ahead_q[LEVELS-2:0], 1'b1};
  end

  // Decision and shift network.
  assign hit  = |eq_q;
  assign full = (n_q == CNT_W'(LEVELS));
  assign drop = full && ahead_q[LEVELS-1];

  always_comb begin
    status_d = ST_MISSED;
    n_next   = n_q;
    for (int i = 0; i < LEVELS; i++) begin
      nxt_pr[i] = cur_pr[i];
      nxt_qt[i] = cur_qt[i];
    end
    if (q_q == '0) begin
      if (hit) begin
        // Levels at and behind the removed price move up by one.
        status_d = ST_REMOVED;
        n_next   = n_q - CNT_W'(1);
        for (int i = 0; i < LEVELS; i++) begin
          if (vld[i] && !ahead_q[i]) begin
            nxt_pr[i] = up_pr[i];
            nxt_qt[i] = up_qt[i];
          end
        end
      end else begin
        status_d = ST_MISSED;
      end
    end else if (hit) begin
      status_d = ST_UPDATED;
      for (int i = 0; i < LEVELS; i++) begin
        if (eq_q[i]) begin
          nxt_qt[i] = q_q;
        end
      end
    end else if (drop) begin
      status_d = ST_DROPPED;
    end else begin
      // Levels behind the new price move down; a full table loses its worst.
      status_d = full ? ST_EVICTED : ST_INSERTED;
      n_next   = full ? n_q : (n_q + CNT_W'(1));
      for (int i = 0; i < LEVELS; i++) begin
        if (ahead_q[i]) begin
          nxt_pr[i] = cur_pr[i];
          nxt_qt[i] = cur_qt[i];
        end else if (prev_ahead[i]) begin
          nxt_pr[i] = p_q;
          nxt_qt[i] = q_q;
        end else begin
          nxt_pr[i] = dn_pr[i];
          nxt_qt[i] = dn_qt[i];
        end
      end
    end
  end

  // Table rows are written back on apply.
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      for (int i = 0; i < LEVELS; i++) begin
        pr_q[side_q][i] <= nxt_pr[i];
        qt_q[side_q][i] <= nxt_qt[i];
      end
    end
  end

  // Occupied counts are cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
    end else if (cmd_i.apply) begin
      cnt_q[side_q] <= n_next;
    end
  end

  // Result register: top of the updated side.
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      status_q <= status_d;
      count_q  <= FIELD_COUNT'(n_next);
      if (n_next == '0) begin
        best_price_q <= '0;
        best_qty_q   <= '0;
      end else begin
        best_price_q <= FIELD_PRICE'(nxt_pr[0]);
        best_qty_q   <= FIELD_QTY'(nxt_qt[0]);
      end
    end
  end

  assign status_o      = status_q;
  assign best_price_o  = best_price_q;
  assign best_qty_o    = best_qty_q;
  assign level_count_o = count_q;

endmodule
`default_nettype wire

### bench/order_book_level_update_checker.sv
// Checker for the order book level update block: watches both channels,
// keeps its own copy of the two price-level tables and compares every result.
// Depends on obu_pkg for the table depth, field widths, sides and status codes.
module order_book_level_update_checker
  import obu_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  input  wire                    in_ready_i,
  input  wire                    side_i,
  input  wire [FIELD_PRICE-1:0]  price_i,
  input  wire [FIELD_QTY-1:0]    qty_i,
  input  wire                    out_valid_i,
  input  wire                    out_ready_i,
  input  wire [2:0]              status_i,
  input  wire [FIELD_PRICE-1:0]  best_price_i,
  input  wire [FIELD_QTY-1:0]    best_qty_i,
  input  wire [FIELD_COUNT-1:0]  level_count_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  // One expected result beat.
  typedef struct packed {
    status_e                status;
    logic [FIELD_PRICE-1:0] best_price;
    logic [FIELD_QTY-1:0]   best_qty;
    logic [FIELD_COUNT-1:0] level_count;
  } book_result_t;

  // Shadow tables, indexed by side, best level first.
  logic [PRICE_BITS-1:0] level_px  [2][LEVELS];
  logic [QTY_BITS-1:0]   level_qty [2][LEVELS];
  int                    level_cnt [2];

  book_result_t expected_q [$];
  int           mismatches = 0;

  assign fail_count_o = mismatches;

  // True when price a ranks ahead of price b on the given side.
  function automatic bit ranks_ahead(input logic side, input logic [PRICE_BITS-1:0] a,
                                     input logic [PRICE_BITS-1:0] b);
    return (side == SIDE_ASK) ? (a < b) : (a > b);
  endfunction

  // Applies one delta level to the shadow tables and returns the result beat.
  function automatic book_result_t apply_delta(input logic side,
                                               input logic [PRICE_BITS-1:0] px,
                                               input logic [QTY_BITS-1:0] qty);
    book_result_t r;
    int           n;
    int           hit;
    int           pos;
    int           i;
    bit           evict;
    n   = level_cnt[side];
    hit = -1;
    for (i = 0; i < n; i++) begin
      if (hit < 0 && level_px[side][i] == px) hit = i;
    end

    if (qty == '0) begin
      // A zero quantity removes the level, closing the gap behind it.
      if (hit >= 0) begin
        for (i = hit; i + 1 < n; i++) begin
          level_px[side][i]  = level_px[side][i+1];
          level_qty[side][i] = level_qty[side][i+1];
        end
        n--;
        r.status = ST_REMOVED;
      end else begin
        r.status = ST_MISSED;
      end
    end else if (hit >= 0) begin
      level_qty[side][hit] = qty;
      r.status = ST_UPDATED;
    end else if (n == LEVELS && !ranks_ahead(side, px, level_px[side][n-1])) begin
      // A full table keeps its levels when the new one is no better.
      r.status = ST_DROPPED;
    end else begin
      // Insert in order, giving up the worst level when the table is full.
      evict = (n == LEVELS);
      if (evict) n--;
      pos = 0;
      while (pos < n && ranks_ahead(side, level_px[side][pos], px)) pos++;
      for (i = n; i > pos; i--) begin
        level_px[side][i]  = level_px[side][i-1];
        level_qty[side][i] = level_qty[side][i-1];
      end
      level_px[side][pos]  = px;
      level_qty[side][pos] = qty;
      n++;
      r.status = evict ? ST_EVICTED : ST_INSERTED;
    end

    level_cnt[side] = n;
    r.best_price  = (n != 0) ? level_px[side][0] : '0;
    r.best_qty    = (n != 0) ? level_qty[side][0] : '0;
    r.level_count = FIELD_COUNT'(n);
    return r;
  endfunction

  // Reports one field that differs from its expected value.
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Input beats feed the shadow tables; result beats are matched in order.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    book_result_t want;
    book_result_t predicted;
    if (!rst_ni) begin
      level_cnt[0] = 0;
      level_cnt[1] = 0;
      expected_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        predicted = apply_delta(side_i, price_i, qty_i);
        expected_q.insert(expected_q.size(), predicted);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, actual status %0d",
                   $time, status_i);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("best_price", 32'(want.best_price), 32'(best_price_i));
          check_field("best_qty", 32'(want.best_qty), 32'(best_qty_i));
          check_field("level_count", 32'(want.level_count), 32'(level_count_i));
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

### bench/order_book_level_update_tb.sv
// Top of the order book level update testbench: clock, reset, stimulus and verdict.
// Depends on obu_pkg, the order_book_level_update block and its checker module.
module order_book_level_update_tb;
  import obu_pkg::*;

  localparam int PHASE_ITEMS    = 100;
  localparam int POOL_SIZE      = 24;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int STALL_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = 8;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   side_i;
  logic [FIELD_PRICE-1:0] price_i;
  logic [FIELD_QTY-1:0]   qty_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [2:0]             status_o;
  logic [FIELD_PRICE-1:0] best_price_o;
  logic [FIELD_QTY-1:0]   best_qty_o;
  logic [FIELD_COUNT-1:0] level_count_o;

  int fail_count;
  int pending;
  int tx_max_gap = 19;
  int rx_max_gap = 19;
  bit rx_hold_req = 1'b0;

  logic [FIELD_PRICE-1:0] price_pool [2][POOL_SIZE];

  // Clock with a period of four time units.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  order_book_level_update u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .side_i        (side_i),
    .price_i       (price_i),
    .qty_i         (qty_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .best_price_o  (best_price_o),
    .best_qty_o    (best_qty_o),
    .level_count_o (level_count_o)
  );

  order_book_level_update_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .side_i        (side_i),
    .price_i       (price_i),
    .qty_i         (qty_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status_o),
    .best_price_i  (best_price_o),
    .best_qty_i    (best_qty_o),
    .level_count_i (level_count_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Offers one delta beat after a random gap and returns at the edge that takes it.
  task automatic send_delta(input logic side, input logic [FIELD_PRICE-1:0] px,
                            input logic [FIELD_QTY-1:0] qty);
    int gap;
    gap = $urandom_range(tx_max_gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    side_i     <= side;
    price_i    <= px;
    qty_i      <= qty;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  // Stops offering beats until every expected result has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Result sink: a random stall before each beat, and one long hold-off on request.
  initial begin : result_sink
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        stall = $urandom_range(rx_max_gap);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (!out_valid_o);
      @(posedge clk_i);
    end
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: watchdog: no beat for %0d cycles", $time, STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Stimulus: directed corner cases, then random phases with varying pressure.
  initial begin : stimulus
    int                     phase;
    int                     k;
    int                     j;
    int                     remove_pct;
    logic                   s;
    logic [FIELD_PRICE-1:0] p;
    logic [FIELD_QTY-1:0]   q;
    logic [FIELD_PRICE-1:0] base;
    logic [FIELD_PRICE-1:0] step;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    side_i      <= SIDE_BID;
    price_i     <= '0;
    qty_i       <= '0;
    out_ready_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bid side: a remove on an empty side, the price and quantity extremes,
    // an overwrite, a removal and a remove of an absent price.
    send_delta(SIDE_BID, 32'd100, '0);
    send_delta(SIDE_BID, '0, 32'd1);
    send_delta(SIDE_BID, '1, '1);
    send_delta(SIDE_BID, '1, 32'd5);
    send_delta(SIDE_BID, '0, '0);
    send_delta(SIDE_BID, 32'd12345, '0);

    // Ask side: fill the table from worst to best so every insert lands at the
    // top, then evict with a better price, drop a worse one and evict again.
    for (j = 0; j < LEVELS; j++) begin
      send_delta(SIDE_ASK, FIELD_PRICE'(100 * (LEVELS - j)), FIELD_QTY'(j + 1));
    end
    send_delta(SIDE_ASK, 32'd50, 32'd9);
    send_delta(SIDE_ASK, 32'd2000, 32'd3);
    send_delta(SIDE_ASK, '0, '1);
    wait_drained();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin tx_max_gap = 19; rx_max_gap = 19; remove_pct = 20; end
        1: begin tx_max_gap = 0;  rx_max_gap = 0;  remove_pct = 35; end
        2: begin tx_max_gap = 0;  rx_max_gap = 19; remove_pct = 10; end
        3: begin tx_max_gap = 19; rx_max_gap = 0;  remove_pct = 45; end
        default: begin tx_max_gap = 19; rx_max_gap = 19; remove_pct = 25; end
      endcase

      // A fresh pool of prices per side makes hits, full tables and evictions common.
      for (j = 0; j < 2; j++) begin
        base = $urandom;
        step = $urandom_range(1000, 1);
        for (k = 0; k < POOL_SIZE; k++) price_pool[j][k] = base + FIELD_PRICE'(k) * step;
      end

      // The sink holds off for a long stretch while beats keep coming.
      if (phase == 2) rx_hold_req = 1'b1;

      for (k = 0; k < PHASE_ITEMS; k++) begin
        s = 1'($urandom_range(1));
        if ($urandom_range(99) < 8) begin
          p = $urandom;
          q = ($urandom_range(3) == 0) ? '0 : FIELD_QTY'($urandom);
        end else begin
          p = price_pool[s][$urandom_range(POOL_SIZE - 1)];
          if ($urandom_range(99) < remove_pct) begin
            q = '0;
          end else begin
            case ($urandom_range(7))
              0:       q = '1;
              1:       q = 32'd1;
              default: q = $urandom;
            endcase
          end
        end
        send_delta(s, p, q);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
